// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/sxp_pkg.sv =====
// Package for the STX/ETX frame parser: constants, types, hex helper.
// No dependencies; used by every module of the block but sxp_in_reg and sxp_checker.
`timescale 1ns / 1ps

package sxp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_FRAME_DEF = 256;
    localparam int NUM_CARS_DEF  = 4;
    // Number of car pairs carried by the result word
    localparam int OUT_CARS      = 4;

    // Configuration port geometry
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_NODE_ID = '0;
    localparam logic [7:0] NODE_ID_RST = 8'd49;

    // Character codes
    localparam logic [7:0] CH_STX     = 8'h02;
    localparam logic [7:0] CH_ETX     = 8'h03;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CMD_DIRECT = 8'h31;
    localparam logic [7:0] CMD_CARS   = 8'h32;

    localparam logic [15:0] STEP_MAX = 16'hFFFF;

    // Control from the frame core to the car parser
    typedef struct packed {
        logic       start;   // STX opened a frame
        logic       parse;   // byte belongs to a command '2' body
        logic       commit;  // ETX closed a command '2' frame
        logic [7:0] data;
    } car_ctl_t;

    // Frame-level part of a result word
    typedef struct packed {
        logic [7:0] command;
        logic [7:0] dest_id;
        logic [7:0] direction;
        logic       frame_ok;
    } head_t;

    typedef struct packed {
        head_t                          head;
        logic [OUT_CARS-1:0][7:0]       car_id;
        logic [OUT_CARS-1:0][15:0]      car_steps;
    } result_t;

    // Uppercase ASCII hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'b0000, nib};
        end else begin
            res = 8'h37 + {4'b0000, nib};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/sxp_in_reg.sv =====
// Input register: holds one received word until the core takes it.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module sxp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Accept whenever the slot is empty or being drained this cycle
    assign in_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== rtl/core/sxp_car_parse.sv =====
// Command '2' body parser: colon splitting, id capture, saturating decimal steps.
// Depends on sxp_pkg (car_ctl_t, character codes, OUT_CARS).
`timescale 1ns / 1ps

module sxp_car_parse #(
    parameter int NUM_CARS = sxp_pkg::NUM_CARS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sxp_pkg::car_ctl_t                    ctl,
    output logic [sxp_pkg::OUT_CARS-1:0][7:0]    car_id_view,
    output logic [sxp_pkg::OUT_CARS-1:0][15:0]   car_steps_view
);

    localparam int LIMIT = 2 * NUM_CARS;
    localparam int CC_W  = $clog2(LIMIT + 2);

    logic [CC_W-1:0] cc_reg, cc_next;
    logic            digits_reg, digits_next;
    logic [7:0]      pend_ids_reg   [NUM_CARS];
    logic [7:0]      pend_ids_next  [NUM_CARS];
    logic [15:0]     pend_steps_reg [NUM_CARS];
    logic [15:0]     pend_steps_next[NUM_CARS];
    logic [7:0]      car_ids_reg    [NUM_CARS];
    logic [7:0]      car_ids_next   [NUM_CARS];
    logic [15:0]     car_steps_reg  [NUM_CARS];
    logic [15:0]     car_steps_next [NUM_CARS];
    logic [15:0]     step_acc       [NUM_CARS];

    logic            is_digit;
    logic [3:0]      digit_val;
    logic [CC_W-1:0] cc_inc;
    logic [CC_W-1:0] car_sel;
    logic            in_seg;

    assign is_digit  = (ctl.data >= sxp_pkg::CH_ZERO) && (ctl.data <= sxp_pkg::CH_NINE);
    assign digit_val = ctl.data[3:0];
    assign cc_inc    = (cc_reg <= CC_W'(LIMIT)) ? cc_reg + CC_W'(1) : cc_reg;
    assign car_sel   = (cc_reg - CC_W'(1)) >> 1;
    assign in_seg    = (cc_reg >= CC_W'(1)) && (cc_reg <= CC_W'(LIMIT));

    // Per-car steps*10 + digit, saturated to 16 bits
    for (genvar k = 0; k < NUM_CARS; k++) begin : g_acc
        logic [19:0] wide;
        assign wide = ({4'b0000, pend_steps_reg[k]} << 3)
                    + ({4'b0000, pend_steps_reg[k]} << 1)
                    + {16'h0000, digit_val};
        assign step_acc[k] = (wide > 20'(sxp_pkg::STEP_MAX)) ? sxp_pkg::STEP_MAX
                                                              : wide[15:0];
    end

    // Next state of the pending and committed pairs
    always_comb begin
        cc_next         = cc_reg;
        digits_next     = digits_reg;
        pend_ids_next   = pend_ids_reg;
        pend_steps_next = pend_steps_reg;
        car_ids_next    = car_ids_reg;
        car_steps_next  = car_steps_reg;
        if (ctl.start) begin
            cc_next     = '0;
            digits_next = 1'b0;
            for (int k = 0; k < NUM_CARS; k++) begin
                pend_ids_next[k]   = car_ids_reg[k];
                pend_steps_next[k] = '0;
            end
        end else if (ctl.parse) begin
            if (ctl.data == sxp_pkg::CH_COLON) begin
                cc_next     = cc_inc;
                digits_next = !cc_inc[0] && (cc_inc <= CC_W'(LIMIT));
            end else if (in_seg) begin
                priority if (cc_reg[0]) begin
                    // id segment: last byte wins
                    for (int k = 0; k < NUM_CARS; k++) begin
                        if (car_sel == CC_W'(k)) begin
                            pend_ids_next[k] = ctl.data;
                        end
                    end
                end else if (digits_reg && is_digit) begin
                    for (int k = 0; k < NUM_CARS; k++) begin
                        if (car_sel == CC_W'(k)) begin
                            pend_steps_next[k] = step_acc[k];
                        end
                    end
                end else begin
                    digits_next = 1'b0;
                end
            end
        end else if (ctl.commit) begin
            car_ids_next   = pend_ids_reg;
            car_steps_next = pend_steps_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg     <= '0;
            digits_reg <= 1'b0;
            for (int k = 0; k < NUM_CARS; k++) begin
                pend_ids_reg[k]   <= '0;
                pend_steps_reg[k] <= '0;
                car_ids_reg[k]    <= '0;
                car_steps_reg[k]  <= '0;
            end
        end else begin
            cc_reg         <= cc_next;
            digits_reg     <= digits_next;
            pend_ids_reg   <= pend_ids_next;
            pend_steps_reg <= pend_steps_next;
            car_ids_reg    <= car_ids_next;
            car_steps_reg  <= car_steps_next;
        end
    end

    // Pairs as seen after this word; cars past NUM_CARS read as zero
    for (genvar k = 0; k < sxp_pkg::OUT_CARS; k++) begin : g_view
        if (k < NUM_CARS) begin : g_real
            assign car_id_view[k]    = car_ids_next[k];
            assign car_steps_view[k] = car_steps_next[k];
        end else begin : g_none
            assign car_id_view[k]    = '0;
            assign car_steps_view[k] = '0;
        end
    end

endmodule

// ===== rtl/core/sxp_frame_core.sv =====
// Frame core: STX/ETX framing, length limit, XOR checksum, command fields.
// Depends on sxp_pkg (codes, head_t, car_ctl_t, hex_digit).
`timescale 1ns / 1ps

module sxp_frame_core #(
    parameter int MAX_FRAME = sxp_pkg::MAX_FRAME_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        node_id,
    output logic              done,
    output sxp_pkg::head_t    head,
    output sxp_pkg::car_ctl_t car_ctl
);

    localparam int IDX_W = $clog2(MAX_FRAME + 1);

    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       tail0_reg, tail0_next;
    logic [7:0]       tail1_reg, tail1_next;
    logic [7:0]       tail2_reg, tail2_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       dir_reg, dir_next;
    logic [7:0]       last_dest_reg, last_dest_next;
    logic [7:0]       last_dir_reg, last_dir_next;

    logic [7:0]       cmd_cap, id_cap, dir_cap;
    logic             past_head;

    // Fixed frame positions captured from the current word
    assign cmd_cap   = (idx_reg == IDX_W'(2)) ? rx_byte : cmd_reg;
    assign id_cap    = (idx_reg == IDX_W'(4)) ? rx_byte : id_reg;
    assign dir_cap   = (idx_reg == IDX_W'(6)) ? rx_byte : dir_reg;
    assign past_head = (idx_reg >= IDX_W'(3));

    // Frame state update
    always_comb begin
        in_frame_next  = in_frame_reg;
        idx_next       = idx_reg;
        xor_next       = xor_reg;
        tail0_next     = tail0_reg;
        tail1_next     = tail1_reg;
        tail2_next     = tail2_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        dir_next       = dir_reg;
        last_dest_next = last_dest_reg;
        last_dir_next  = last_dir_reg;
        done           = 1'b0;
        car_ctl        = '0;
        car_ctl.data   = rx_byte;
        if (step) begin
            priority if (!in_frame_reg) begin
                if (rx_byte == sxp_pkg::CH_STX) begin
                    in_frame_next = 1'b1;
                    idx_next      = IDX_W'(1);
                    xor_next      = '0;
                    tail0_next    = '0;
                    tail1_next    = '0;
                    tail2_next    = sxp_pkg::CH_STX;
                    cmd_next      = '0;
                    id_next       = '0;
                    dir_next      = '0;
                    car_ctl.start = 1'b1;
                end
            end else if (idx_reg >= IDX_W'(MAX_FRAME)) begin
                // over length: drop frame and this word
                in_frame_next = 1'b0;
            end else if (rx_byte != sxp_pkg::CH_ETX) begin
                cmd_next      = cmd_cap;
                id_next       = id_cap;
                dir_next      = dir_cap;
                car_ctl.parse = (cmd_cap == sxp_pkg::CMD_CARS) && past_head;
                if (past_head) begin
                    xor_next = xor_reg ^ tail0_reg;
                end
                tail0_next = tail1_reg;
                tail1_next = tail2_reg;
                tail2_next = rx_byte;
                idx_next   = idx_reg + IDX_W'(1);
            end else begin
                cmd_next      = cmd_cap;
                id_next       = id_cap;
                dir_next      = dir_cap;
                in_frame_next = 1'b0;
                done          = 1'b1;
                if (cmd_cap == sxp_pkg::CMD_DIRECT) begin
                    last_dest_next = id_cap;
                    last_dir_next  = dir_cap;
                end
                car_ctl.commit = (cmd_cap == sxp_pkg::CMD_CARS);
            end
        end
    end

    // Result fields for the ETX word
    always_comb begin
        head.command   = cmd_cap;
        head.dest_id   = last_dest_next;
        head.direction = last_dir_next;
        head.frame_ok  = past_head
                      && (tail0_reg == sxp_pkg::hex_digit(xor_reg[7:4]))
                      && (tail1_reg == sxp_pkg::hex_digit(xor_reg[3:0]))
                      && (last_dest_next == node_id);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            idx_reg       <= '0;
            xor_reg       <= '0;
            tail0_reg     <= '0;
            tail1_reg     <= '0;
            tail2_reg     <= '0;
            cmd_reg       <= '0;
            id_reg        <= '0;
            dir_reg       <= '0;
            last_dest_reg <= '0;
            last_dir_reg  <= '0;
        end else begin
            in_frame_reg  <= in_frame_next;
            idx_reg       <= idx_next;
            xor_reg       <= xor_next;
            tail0_reg     <= tail0_next;
            tail1_reg     <= tail1_next;
            tail2_reg     <= tail2_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            dir_reg       <= dir_next;
            last_dest_reg <= last_dest_next;
            last_dir_reg  <= last_dir_next;
        end
    end

endmodule

// ===== rtl/core/sxp_out_reg.sv =====
// Result register: holds one result word until the sink takes it.
// Depends on sxp_pkg (result_t).
`timescale 1ns / 1ps

module sxp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sxp_pkg::result_t load_data,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output sxp_pkg::result_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    sxp_pkg::result_t data_reg;

    // Slot can take a new word when empty or being emptied now
    assign free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/stx_etx_frame_parser_xor_check.sv =====
// Top level of the STX/ETX frame parser with XOR check and command decode.
// Depends on sxp_pkg, sxp_in_reg, sxp_frame_core, sxp_car_parse, sxp_out_reg.
//
//   channel | handshake                   | payload
//   s_      | s_valid / s_ready           | s_rx_byte
//   m_      | m_valid / m_ready           | m_command .. m_car3_steps
//   apb     | psel, penable, pwrite       | paddr, pwdata, prdata (pready = 1)
//
// One received word per cycle, back to back, while the result register is free.
// A word is registered on acceptance and processed once the result register is
// free; an ETX then loads its result into the result register, which raises m_valid.
// Reset is synchronous and returns node_id to 49. While a result waits, the
// word in the input register waits too; s_ready drops only while the input
// register is full and the waiting result is not being taken.
`timescale 1ns / 1ps

module stx_etx_frame_parser_xor_check #(
    parameter int MAX_FRAME = sxp_pkg::MAX_FRAME_DEF,
    parameter int NUM_CARS  = sxp_pkg::NUM_CARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sxp_pkg::PADDR_W-1:0]  paddr,
    input  logic [sxp_pkg::PDATA_W-1:0]  pwdata,
    output logic [sxp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // received words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_command,
    output logic [7:0]                   m_dest_id,
    output logic [7:0]                   m_direction,
    output logic                         m_frame_ok,
    output logic [7:0]                   m_car0_id,
    output logic [15:0]                  m_car0_steps,
    output logic [7:0]                   m_car1_id,
    output logic [15:0]                  m_car1_steps,
    output logic [7:0]                   m_car2_id,
    output logic [15:0]                  m_car2_steps,
    output logic [7:0]                   m_car3_id,
    output logic [15:0]                  m_car3_steps
);

    logic [7:0] node_id_reg;
    logic       cfg_write;
    logic       sel_node_id;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_free;
    logic       fire;
    logic       done;

    sxp_pkg::head_t    head;
    sxp_pkg::car_ctl_t car_ctl;
    sxp_pkg::result_t  res_next;
    sxp_pkg::result_t  res_out;
    logic [sxp_pkg::OUT_CARS-1:0][7:0]  car_id_view;
    logic [sxp_pkg::OUT_CARS-1:0][15:0] car_steps_view;

    // Configuration register
    assign pready      = 1'b1;
    assign sel_node_id = (paddr[sxp_pkg::PADDR_W-1:2] == sxp_pkg::REG_NODE_ID);
    assign cfg_write   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= sxp_pkg::NODE_ID_RST;
        end else if (cfg_write && sel_node_id) begin
            node_id_reg <= pwdata[7:0];
        end
    end

    assign prdata = sel_node_id ? {{(sxp_pkg::PDATA_W-8){1'b0}}, node_id_reg} : '0;

    // Word moves from input register into the core when the result slot is free
    assign fire = held_valid && out_free;

    sxp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_rx_byte),
        .take       (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sxp_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .rx_byte   (held_byte),
        .node_id   (node_id_reg),
        .done      (done),
        .head      (head),
        .car_ctl   (car_ctl)
    );

    sxp_car_parse #(
        .NUM_CARS (NUM_CARS)
    ) u_cars (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (car_ctl),
        .car_id_view    (car_id_view),
        .car_steps_view (car_steps_view)
    );

    always_comb begin
        res_next.head      = head;
        res_next.car_id    = car_id_view;
        res_next.car_steps = car_steps_view;
    end

    sxp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && done),
        .load_data (res_next),
        .free      (out_free),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    // Result fields
    assign m_command    = res_out.head.command;
    assign m_dest_id    = res_out.head.dest_id;
    assign m_direction  = res_out.head.direction;
    assign m_frame_ok   = res_out.head.frame_ok;
    assign m_car0_id    = res_out.car_id[0];
    assign m_car0_steps = res_out.car_steps[0];
    assign m_car1_id    = res_out.car_id[1];
    assign m_car1_steps = res_out.car_steps[1];
    assign m_car2_id    = res_out.car_id[2];
    assign m_car2_steps = res_out.car_steps[2];
    assign m_car3_id    = res_out.car_id[3];
    assign m_car3_steps = res_out.car_steps[3];

endmodule

// ===== rtl/core/sxp_checker.sv =====
// Port-level checker for the frame parser top level, with its bind.
// Depends on assert_macros.svh and stx_etx_frame_parser_xor_check.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sxp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_command,
    input logic [7:0]  m_dest_id,
    input logic        m_frame_ok
);

    // Stalled result holds its word
    `ASSERT_CLK(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_command) && $stable(m_dest_id) && $stable(m_frame_ok))

    // Reset empties the result register
    `ASSERT_CLK_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid)

    // With the result slot empty, input is never held off
    `ASSERT_CLK(a_ready_free, aclk, aresetn, !m_valid |-> s_ready)

    // A new result traces back to an accepted word, registered in the input and then the result register
    `ASSERT_CLK(a_latency, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 2))

endmodule

bind stx_etx_frame_parser_xor_check sxp_checker u_sxp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_command  (m_command),
    .m_dest_id  (m_dest_id),
    .m_frame_ok (m_frame_ok)
);

// ===== dv/tb_top.sv =====
// Testbench for the STX/ETX frame parser: directed and random byte streams,
// a word-by-word frame decoder kept in step, and an in-order result check.
// Depends on sxp_pkg and stx_etx_frame_parser_xor_check.
`timescale 1ns / 1ps

module tb_top;
    import sxp_pkg::*;

    localparam int FRAME_LIMIT  = MAX_FRAME_DEF;
    localparam int CARS         = NUM_CARS_DEF;
    localparam int COLON_LIMIT  = 2 * CARS;
    localparam int RANDOM_WORDS = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [PADDR_W-1:0] NODE_ID_ADDR = {REG_NODE_ID, 2'b00};
    localparam logic [7:0] DIR_FWD     = 8'h46;  // 'F'
    localparam logic [7:0] DIR_STOP    = 8'h53;  // 'S'
    localparam logic [7:0] CMD_UNKNOWN = 8'h5A;  // 'Z'

    typedef logic [7:0] byte_q_t[$];

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [7:0]           m_command, m_dest_id, m_direction;
    logic                 m_frame_ok;
    logic [7:0]           m_car0_id, m_car1_id, m_car2_id, m_car3_id;
    logic [15:0]          m_car0_steps, m_car1_steps, m_car2_steps, m_car3_steps;

    stx_etx_frame_parser_xor_check uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_dest_id    (m_dest_id),
        .m_direction  (m_direction),
        .m_frame_ok   (m_frame_ok),
        .m_car0_id    (m_car0_id),
        .m_car0_steps (m_car0_steps),
        .m_car1_id    (m_car1_id),
        .m_car1_steps (m_car1_steps),
        .m_car2_id    (m_car2_id),
        .m_car2_steps (m_car2_steps),
        .m_car3_id    (m_car3_id),
        .m_car3_steps (m_car3_steps)
    );

    // Test control
    bit        steady     = 1'b0;  // no idling on either side
    int        hold_reqs  = 0;
    int        holds_done = 0;
    int        errors     = 0;
    int        sent_words = 0;
    int        cycles     = 0;
    result_t   pending_frames[$];

    // Decoder state, mirrors the block
    logic [7:0]  dev_id;
    logic        in_frame_m;
    int          stored;
    logic [7:0]  xor_sum;
    logic [7:0]  tail_q[3];       // [0] is the oldest
    int          colons;
    logic [7:0]  cmd_at2, id_at4, dir_at6;
    logic [7:0]  last_dest, last_dir;
    logic [7:0]  car_id_st[CARS];
    logic [15:0] car_steps_st[CARS];
    logic        in_digits;
    logic [7:0]  open_ids[CARS];
    logic [15:0] open_steps[CARS];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    //------------------------------------------------------------------
    // Frame decoder
    //------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    task automatic clear_decoder;
        dev_id     = NODE_ID_RST;
        in_frame_m = 1'b0;
        stored     = 0;
        xor_sum    = '0;
        tail_q     = '{default: 8'h00};
        colons     = 0;
        cmd_at2    = '0;
        id_at4     = '0;
        dir_at6    = '0;
        last_dest  = '0;
        last_dir   = '0;
        in_digits  = 1'b0;
        for (int k = 0; k < CARS; k++) begin
            car_id_st[k]    = '0;
            car_steps_st[k] = '0;
            open_ids[k]     = '0;
            open_steps[k]   = '0;
        end
    endtask

    // Colon-separated id / step-count pairs of a command '2' body
    task automatic track_car_field(input logic [7:0] b);
        int car;
        int v;
        if (b == CH_COLON) begin
            if (colons <= COLON_LIMIT) colons++;
            in_digits = (colons % 2 == 0) && (colons <= COLON_LIMIT);
        end else if (colons >= 1 && colons <= COLON_LIMIT) begin
            car = (colons - 1) / 2;
            if (colons % 2 == 1) begin
                open_ids[car] = b;
            end else if (in_digits && b >= CH_ZERO && b <= CH_NINE) begin
                v = int'(open_steps[car]) * 10 + int'(b - CH_ZERO);
                open_steps[car] = (v > 65535) ? STEP_MAX : 16'(v);
            end else begin
                in_digits = 1'b0;
            end
        end
    endtask

    // Advance the decoder by one accepted word; queue a result on ETX
    task automatic decode_rx_byte(input logic [7:0] b);
        result_t r;
        if (!in_frame_m) begin
            if (b == CH_STX) begin
                in_frame_m = 1'b1;
                stored     = 1;
                xor_sum    = '0;
                tail_q     = '{8'h00, 8'h00, CH_STX};
                colons     = 0;
                cmd_at2    = '0;
                id_at4     = '0;
                dir_at6    = '0;
                in_digits  = 1'b0;
                open_ids   = car_id_st;
                for (int k = 0; k < CARS; k++) open_steps[k] = '0;
            end
        end else if (stored >= FRAME_LIMIT) begin
            // too long: this word is dropped with the frame
            in_frame_m = 1'b0;
        end else begin
            if (stored == 2) cmd_at2 = b;
            if (stored == 4) id_at4 = b;
            if (stored == 6) dir_at6 = b;
            if (b != CH_ETX) begin
                if (cmd_at2 == CMD_CARS && stored >= 3) track_car_field(b);
                if (stored >= 3) xor_sum ^= tail_q[0];
                tail_q[0] = tail_q[1];
                tail_q[1] = tail_q[2];
                tail_q[2] = b;
                stored++;
            end else begin
                in_frame_m = 1'b0;
                if (cmd_at2 == CMD_DIRECT) begin
                    last_dest = id_at4;
                    last_dir  = dir_at6;
                end else if (cmd_at2 == CMD_CARS) begin
                    car_id_st    = open_ids;
                    car_steps_st = open_steps;
                end
                r.head.command   = cmd_at2;
                r.head.dest_id   = last_dest;
                r.head.direction = last_dir;
                r.head.frame_ok  = (stored >= 3) &&
                                   (tail_q[0] == hex_char(xor_sum[7:4])) &&
                                   (tail_q[1] == hex_char(xor_sum[3:0])) &&
                                   (last_dest == dev_id);
                for (int k = 0; k < OUT_CARS; k++) begin
                    r.car_id[k]    = (k < CARS) ? car_id_st[k] : 8'h00;
                    r.car_steps[k] = (k < CARS) ? car_steps_st[k] : 16'h0000;
                end
                pending_frames.push_back(r);
            end
        end
    endtask

    //------------------------------------------------------------------
    // Result check
    //------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                $error("result word with nothing expected, command %0h", m_command);
                errors++;
            end else begin
                want = pending_frames.pop_front();
                check_field("command", want.head.command, m_command);
                check_field("dest_id", want.head.dest_id, m_dest_id);
                check_field("direction", want.head.direction, m_direction);
                check_field("frame_ok", want.head.frame_ok, m_frame_ok);
                check_field("car0_id", want.car_id[0], m_car0_id);
                check_field("car0_steps", want.car_steps[0], m_car0_steps);
                check_field("car1_id", want.car_id[1], m_car1_id);
                check_field("car1_steps", want.car_steps[1], m_car1_steps);
                check_field("car2_id", want.car_id[2], m_car2_id);
                check_field("car2_steps", want.car_steps[2], m_car2_steps);
                check_field("car3_id", want.car_id[3], m_car3_id);
                check_field("car3_steps", want.car_steps[3], m_car3_steps);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_done != hold_reqs) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    // Idle cycles are drawn one at a time, about 16 in a hundred
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decode_rx_byte(b);
        sent_words++;
    endtask

    // Stop sending and wait until every expected result has come
    task automatic wait_results_done;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write of the node id, then read it back
    task automatic write_node_id(input logic [7:0] v);
        wait_results_done();
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= NODE_ID_ADDR;
        pwdata  <= {24'h000000, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        dev_id = v;
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("prdata", {8'h00, v}, {8'h00, prdata[7:0]});
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Printable character; with wild set, now and then any byte but ETX
    function automatic logic [7:0] text_char(input bit wild);
        logic [7:0] c;
        if (wild && $urandom_range(0, 9) == 0) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_ETX) c = CH_STX;  // STX inside a frame is plain data
        end else begin
            c = 8'($urandom_range(8'h20, 8'h7E));
        end
        return c;
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // STX, filler, command, body, two hex checksum digits, one byte, ETX
    task automatic send_frame(input logic [7:0] cmd, input byte_q_t body, input bit good);
        byte_q_t    fr;
        logic [7:0] sum;
        fr.push_back(CH_STX);
        fr.push_back(text_char(1'b0));
        fr.push_back(cmd);
        foreach (body[i]) fr.push_back(body[i]);
        sum = '0;
        foreach (fr[i]) sum ^= fr[i];
        if (!good) sum ^= 8'h01 << $urandom_range(0, 7);
        fr.push_back(hex_char(sum[7:4]));
        fr.push_back(hex_char(sum[3:0]));
        fr.push_back(text_char(1'b0));
        fr.push_back(CH_ETX);
        foreach (fr[i]) send_byte(fr[i]);
    endtask

    // Body of a command '2' frame: segs colon-led segments, id / count alternating
    function automatic byte_q_t cars_body(input int segs, input bit wild);
        byte_q_t q;
        int      n;
        for (int s = 1; s <= segs; s++) begin
            q.push_back(CH_COLON);
            if (s % 2 == 1) begin
                n = $urandom_range(0, 9);
                n = (n == 0) ? 0 : (n == 1) ? 2 : 1;
                repeat (n) q.push_back(text_char(wild));
            end else begin
                case ($urandom_range(0, 9))
                    0: ;  // empty count
                    1: begin
                        q.push_back(8'($urandom_range(8'h41, 8'h5A)));
                        repeat ($urandom_range(0, 3))
                            q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    2: repeat ($urandom_range(5, 8))
                        q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: begin
                        repeat ($urandom_range(1, 4))
                            q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        if ($urandom_range(0, 7) == 0) q.push_back(text_char(wild));
                    end
                endcase
            end
        end
        return q;
    endfunction

    task automatic send_random_frame;
        byte_q_t body;
        bit      good;
        int      kind;
        good = ($urandom_range(0, 99) < 85);
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            body = cars_body($urandom_range(1, 10), 1'b1);
            send_frame(CMD_CARS, body, good);
        end else if (kind < 70) begin
            body.push_back(text_char(1'b1));
            body.push_back(($urandom_range(0, 3) != 0) ? dev_id : text_char(1'b1));
            body.push_back(text_char(1'b1));
            body.push_back($urandom_range(0, 1) ? DIR_FWD : DIR_STOP);
            repeat ($urandom_range(0, 3)) body.push_back(text_char(1'b1));
            send_frame(CMD_DIRECT, body, good);
        end else if (kind < 80) begin
            repeat ($urandom_range(0, 5)) body.push_back(text_char(1'b1));
            send_frame(text_char(1'b1), body, good);
        end else if (kind < 90) begin
            // broken frame, often too short for a checksum
            send_byte(CH_STX);
            repeat ($urandom_range(0, 6)) send_byte(text_char(1'b1));
            send_byte(CH_ETX);
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Command '1' against the reset id, good and bad checksum
    task automatic test_direct_command;
        send_frame(CMD_DIRECT, text_bytes("x1xF"), 1'b1);
        send_frame(CMD_DIRECT, text_bytes("a1bS"), 1'b0);
    endtask

    // Command '2': saturation, empty segments, non-digit counts, extra colons
    task automatic test_car_command;
        send_frame(CMD_CARS, text_bytes(":A:120:B:65535:C:99999:D:7"), 1'b1);
        send_frame(CMD_CARS, text_bytes("::x12:QR::E:5:F:6:G:7:H:8:I:9"), 1'b0);
    endtask

    // Unknown commands report only the header fields
    task automatic test_other_commands;
        send_frame(8'hFF, text_bytes("abc"), 1'b1);
        send_frame(8'h00, text_bytes(""), 1'b0);
        send_frame(CMD_UNKNOWN, text_bytes("q"), 1'b1);
    endtask

    // Words outside a frame, short frames, STX as frame data
    task automatic test_short_frames;
        send_byte(8'h55);
        send_byte(CH_ETX);
        send_byte(CH_STX);
        send_byte(CH_ETX);
        send_byte(CH_STX);
        send_byte(8'h61);
        send_byte(CH_ETX);
        send_byte(CH_STX);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(CH_ETX);
        send_byte(CH_STX);
        send_byte(CH_STX);
        send_byte(CMD_DIRECT);
        send_byte(CH_ETX);
    endtask

    // Id extremes; a '2' frame is checked against the last '1' id
    task automatic test_node_id;
        byte_q_t body;
        write_node_id(8'h00);
        body    = text_bytes("xXxS");
        body[1] = 8'h00;
        send_frame(CMD_DIRECT, body, 1'b1);
        send_frame(CMD_CARS, text_bytes(":K:42"), 1'b1);
        write_node_id(8'hFF);
        body[1] = 8'hFF;
        body[3] = DIR_FWD;
        send_frame(CMD_DIRECT, body, 1'b1);
        send_frame(CMD_CARS, text_bytes(":M:0:N"), 1'b1);
        write_node_id(NODE_ID_RST);
    endtask

    // Frames at and past the length limit
    task automatic test_length_limit;
        byte_q_t body;
        repeat (FRAME_LIMIT - 7) body.push_back(text_char(1'b0));
        send_frame(CMD_CARS, body, 1'b1);     // last stored byte in range
        body.push_back(text_char(1'b0));
        send_frame(CMD_CARS, body, 1'b1);     // ETX itself drops the frame
        send_frame(CMD_DIRECT, text_bytes("x1xF"), 1'b1);
    endtask

    // Long output stall while words keep coming: the input must back up
    task automatic test_output_stall;
        wait_results_done();
        steady = 1'b1;
        hold_reqs++;
        repeat (12) send_frame(CMD_UNKNOWN, text_bytes(""), 1'b1);
        wait_results_done();
        steady = 1'b0;
    endtask

    // Random frames over several id settings, one phase without idling
    task automatic test_random_traffic;
        logic [7:0] ids[4];
        int         goal;
        ids[0] = NODE_ID_RST;
        ids[1] = 8'($urandom_range(8'h30, 8'h39));
        ids[2] = 8'($urandom_range(0, 255));
        ids[3] = 8'($urandom_range(8'h41, 8'h5A));
        for (int p = 0; p < 4; p++) begin
            write_node_id(ids[p]);
            steady = (p == 2);
            goal   = sent_words + RANDOM_WORDS / 4;
            while (sent_words < goal) send_random_frame();
        end
        steady = 1'b0;
    endtask

    initial begin
        clear_decoder();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_direct_command();
        test_car_command();
        test_other_commands();
        test_short_frames();
        test_node_id();
        test_length_limit();
        test_output_stall();
        test_random_traffic();

        wait_results_done();
        if (errors == 0 && pending_frames.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sxp_pkg.sv
rtl/core/sxp_in_reg.sv
rtl/core/sxp_car_parse.sv
rtl/core/sxp_frame_core.sv
rtl/core/sxp_out_reg.sv
rtl/core/stx_etx_frame_parser_xor_check.sv
rtl/core/sxp_checker.sv
dv/tb_top.sv
